// ===== hw/rtl/hkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hkc_pkg;

   localparam int MAX_KEYS = 64;
   localparam int KEY_AW   = $clog2(MAX_KEYS);
   localparam int CNT_W    = KEY_AW + 1;
   localparam int H_W      = 16;
   localparam int MC_W     = $clog2(H_W);
   localparam int BASE_W   = 52;

   localparam logic [2:0] RQ_ADD   = 3'd0;
   localparam logic [2:0] RQ_DEL   = 3'd1;
   localparam logic [2:0] RQ_EVAL  = 3'd2;
   localparam logic [2:0] RQ_BUILD = 3'd3;
   localparam logic [2:0] RQ_CLEAR = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_CLOSE = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   localparam logic CSR_MIN_GAP = 1'b0;
   localparam logic CSR_BIAS    = 1'b1;

   localparam logic [31:0] MIN_GAP_RST = 32'd2560;
   localparam logic [31:0] BIAS_RST    = 32'd32768;

   localparam logic [MC_W-1:0] DIV_LAST   = MC_W'(H_W - 1);
   localparam logic [MC_W-1:0] MAC_LAST   = MC_W'(11);
   localparam logic [MC_W-1:0] TCOMP_LAST = MC_W'(2);

   typedef struct packed {
      logic        [31:0] kt;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } val_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } tan_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_DISPATCH, OP_SRCH_RD, OP_SRCH_CMP, OP_RD_A, OP_RD_B, OP_LAT_B,
      OP_ADD_CHECK, OP_SH_RD, OP_SH_WR, OP_INS_WR, OP_EV_CHECK, OP_DIV, OP_BAS1,
      OP_BAS2, OP_BAS3, OP_MUL, OP_ACC, OP_TAN_RDP, OP_TAN_RDN, OP_TAN_LAT, OP_TMUL,
      OP_TACC, OP_TAN_WR, OP_DEL_RD, OP_DEL_WR, OP_DEL_END, OP_FINISH
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SRCH_RD, S_SRCH_CMP, S_RD_A, S_RD_B, S_LAT_B,
      S_ADD_CHECK, S_SH_RD, S_SH_WR, S_EV_CHECK, S_DIV, S_BAS1, S_BAS2, S_BAS3,
      S_MUL, S_ACC, S_TAN_RDP, S_TAN_RDN, S_TAN_LAT, S_TMUL, S_TACC, S_TAN_WR,
      S_DEL_RD, S_DEL_WR, S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      idle;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_add;
      logic is_del;
      logic is_eval;
      logic is_build;
      logic cnt_zero;
      logic cnt_one;
      logic full;
      logic kidx_bad;
      logic srch_done;
      logic too_close;
      logic ev_blend;
      logic sh_done;
      logic del_done;
      logic div_done;
      logic mac_last;
      logic tcomp_last;
      logic tan_last;
      logic out_busy;
   } dp_stat_type;

   function automatic logic signed [31:0] val_comp(input val_type v, input logic [1:0] s);
      logic signed [31:0] r;
      case (s)
         2'd0:    r = v.x;
         2'd1:    r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] tan_comp(input tan_type v, input logic [1:0] s);
      logic signed [31:0] r;
      case (s)
         2'd0:    r = v.x;
         2'd1:    r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   // Q32.32 product to Q16.16, ties away from zero
   function automatic logic signed [31:0] card_round(input logic signed [65:0] p);
      logic signed [65:0] m;
      if (p >= 66'sd0) begin
         m = (p + 66'sd32768) >>> 16;
         return sat66(m);
      end else begin
         m = ((-p) + 66'sd32768) >>> 16;
         return sat66(-m);
      end
   endfunction

   // Q48 basis to Q2.30, round half up
   function automatic logic signed [31:0] base_round(input logic signed [BASE_W-1:0] v);
      logic signed [BASE_W-1:0] s;
      s = (v + BASE_W'(131072)) >>> 18;
      return s[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hkc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hkc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic [31:0]        at_time;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_z;
   logic [5:0]         key_index;
   modport source (output valid, req_type, at_time, in_x, in_y, in_z, key_index,
                   input ready);
   modport sink (input valid, req_type, at_time, in_x, in_y, in_z, key_index,
                 output ready);
endinterface

interface hkc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [5:0]         key_pos;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [6:0]         key_total;
   modport source (output valid, status, key_pos, out_x, out_y, out_z, key_total,
                   input ready);
   modport sink (input valid, status, key_pos, out_x, out_y, out_z, key_total,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hkc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/hkc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hkc_datapath
   import hkc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   hkc_req_if.sink          req_ch,
   hkc_rsp_if.source        rsp_ch,
   input  dp_cmd_type       cmd,
   output dp_stat_type      stat
);
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      gap_ff, gap_in;
   logic signed [31:0] bias_ff, bias_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [2:0]         rtype_ff, rtype_in;
   logic [31:0]        t_ff, t_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [KEY_AW-1:0]  kidx_ff, kidx_in;
   logic [CNT_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [KEY_AW-1:0]  mid_ff, mid_in;
   val_type            reca_ff, reca_in, recb_ff, recb_in;
   tan_type            tana_ff, tana_in, tanb_ff, tanb_in;
   logic [31:0]        rem_ff, rem_in, dt_ff, dt_in;
   logic [H_W-1:0]     quot_ff, quot_in;
   logic [31:0]        u2_ff, u2_in;
   logic [47:0]        u3_ff, u3_in;
   logic signed [31:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic [MC_W-1:0]    mcnt_ff, mcnt_in;
   logic signed [65:0] prod_ff, prod_in, acc_ff, acc_in;
   tan_type            vres_ff, vres_in;
   logic [2:0]         status_ff, status_in;
   logic [KEY_AW-1:0]  pos_ff, pos_in;
   logic [2:0]         o_status_ff, o_status_in;
   logic [KEY_AW-1:0]  o_pos_ff, o_pos_in;
   tan_type            o_val_ff, o_val_in;
   logic [CNT_W-1:0]   o_total_ff, o_total_in;

   logic [KEY_AW-1:0] ram_raddr, ram_waddr;
   logic              val_we, tan_we;
   val_type           val_wdata, rd_val;
   tan_type           tan_wdata, rd_tan;

   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   a_idx;
   logic               c_nz, c_lt_n, same;
   logic [31:0]        gap_l, gap_r, dt;
   logic [32:0]        r2;
   logic               r_ge;
   logic [1:0]         comp, term;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p, acc_sum, acc_rnd;
   logic signed [31:0] blend_res, card_res;
   logic signed [BASE_W-1:0] h2, h3, uu, one48;

   hkc_ram #(.WIDTH($bits(val_type)), .DEPTH(MAX_KEYS)) u_val_ram (
      .clock(clock), .we(val_we), .waddr(ram_waddr), .wdata(val_wdata),
      .raddr(ram_raddr), .rdata(rd_val)
   );
   hkc_ram #(.WIDTH($bits(tan_type)), .DEPTH(MAX_KEYS)) u_tan_ram (
      .clock(clock), .we(tan_we), .waddr(ram_waddr), .wdata(tan_wdata),
      .raddr(ram_raddr), .rdata(rd_tan)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign c_nz    = lo_ff != '0;
   assign c_lt_n  = lo_ff < count_ff;
   assign a_idx   = c_nz ? lo_ff - CNT_W'(1) : '0;
   assign gap_l   = t_ff - reca_ff.kt;
   assign gap_r   = recb_ff.kt - t_ff;
   assign dt      = recb_ff.kt - reca_ff.kt;
   assign same    = reca_ff.x == recb_ff.x && reca_ff.y == recb_ff.y
                    && reca_ff.z == recb_ff.z;
   assign r2      = {rem_ff, 1'b0};
   assign r_ge    = r2 >= {1'b0, dt_ff};
   assign comp    = mcnt_ff[3:2];
   assign term    = mcnt_ff[1:0];

   assign h2    = $signed({4'b0, u2_ff, 16'b0});
   assign h3    = $signed({4'b0, u3_ff});
   assign uu    = $signed({4'b0, quot_ff, 32'b0});
   assign one48 = $signed({4'b0001, 48'b0});

   // shared multiplier: blend terms or tangent differences
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == OP_TMUL) begin
         mul_a = 33'(val_comp(recb_ff, mcnt_ff[1:0])) - 33'(val_comp(reca_ff, mcnt_ff[1:0]));
         mul_b = 33'(bias_ff);
      end else begin
         case (term)
            2'd0: begin mul_a = 33'(val_comp(reca_ff, comp)); mul_b = 33'(b0_ff); end
            2'd1: begin mul_a = 33'(val_comp(recb_ff, comp)); mul_b = 33'(b1_ff); end
            2'd2: begin mul_a = 33'(tan_comp(tana_ff, comp)); mul_b = 33'(b2_ff); end
            default: begin mul_a = 33'(tan_comp(tanb_ff, comp)); mul_b = 33'(b3_ff); end
         endcase
      end
   end

   assign mul_p     = mul_a * mul_b;
   assign acc_sum   = acc_ff + prod_ff;
   assign acc_rnd   = (acc_sum + 66'sd536870912) >>> 30;
   assign blend_res = sat66(acc_rnd);
   assign card_res  = card_round(prod_ff);

   always_comb begin
      count_in = count_ff; gap_in = gap_ff; bias_in = bias_ff;
      rtype_in = rtype_ff; t_in = t_ff; vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      kidx_in = kidx_ff; lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff; mid_in = mid_ff;
      reca_in = reca_ff; recb_in = recb_ff; tana_in = tana_ff; tanb_in = tanb_ff;
      rem_in = rem_ff; dt_in = dt_ff; quot_in = quot_ff; u2_in = u2_ff; u3_in = u3_ff;
      b0_in = b0_ff; b1_in = b1_ff; b2_in = b2_ff; b3_in = b3_ff;
      mcnt_in = mcnt_ff; prod_in = prod_ff; acc_in = acc_ff; vres_in = vres_ff;
      status_in = status_ff; pos_in = pos_ff;
      o_status_in = o_status_ff; o_pos_in = o_pos_ff; o_val_in = o_val_ff;
      o_total_in = o_total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ram_raddr = '0; ram_waddr = '0; val_we = 1'b0; tan_we = 1'b0;
      val_wdata = rd_val; tan_wdata = rd_tan;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_GAP: gap_in  = csr_wdata;
            CSR_BIAS:    bias_in = csr_wdata;
            default: ;
         endcase
      end

      if (req_ch.valid && cmd.idle) begin
         rtype_in = req_ch.req_type; t_in = req_ch.at_time;
         vx_in = req_ch.in_x; vy_in = req_ch.in_y; vz_in = req_ch.in_z;
         kidx_in = req_ch.key_index;
      end

      unique case (cmd.op) inside
         OP_DISPATCH: begin
            status_in = ST_OK; pos_in = '0; vres_in = '0;
            lo_in = '0; hi_in = count_ff;
            idx_in = (rtype_ff == RQ_DEL) ? {1'b0, kidx_ff} : '0;
            case (rtype_ff)
               RQ_ADD:   if (stat.full) status_in = ST_FULL;
               RQ_DEL:   if (stat.kidx_bad) status_in = ST_BAD;
               RQ_EVAL:  if (stat.cnt_zero) status_in = ST_EMPTY;
               RQ_BUILD: if (stat.cnt_zero) status_in = ST_EMPTY;
               RQ_CLEAR: count_in = '0;
               default: ;
            endcase
         end
         OP_SRCH_RD: begin
            mid_in = mid_sum[KEY_AW:1];
            ram_raddr = mid_sum[KEY_AW:1];
         end
         OP_SRCH_CMP: begin
            if (rd_val.kt <= t_ff) lo_in = {1'b0, mid_ff} + CNT_W'(1);
            else hi_in = {1'b0, mid_ff};
         end
         OP_RD_A: ram_raddr = a_idx[KEY_AW-1:0];
         OP_RD_B: begin
            ram_raddr = lo_ff[KEY_AW-1:0];
            reca_in = rd_val; tana_in = rd_tan;
         end
         OP_LAT_B: begin recb_in = rd_val; tanb_in = rd_tan; end
         OP_ADD_CHECK: begin
            if (stat.too_close) status_in = ST_CLOSE;
            else pos_in = lo_ff[KEY_AW-1:0];
            idx_in = count_ff;
         end
         OP_SH_RD: ram_raddr = KEY_AW'(idx_ff - CNT_W'(1));
         OP_SH_WR: begin
            ram_waddr = idx_ff[KEY_AW-1:0]; val_we = 1'b1; tan_we = 1'b1;
            idx_in = idx_ff - CNT_W'(1);
         end
         OP_INS_WR: begin
            ram_waddr = lo_ff[KEY_AW-1:0]; val_we = 1'b1; tan_we = 1'b1;
            val_wdata = '{kt: t_ff, x: vx_ff, y: vy_ff, z: vz_ff};
            tan_wdata = '0;
            count_in = count_ff + CNT_W'(1);
         end
         OP_EV_CHECK: begin
            pos_in = a_idx[KEY_AW-1:0];
            vres_in = '{x: reca_ff.x, y: reca_ff.y, z: reca_ff.z};
            rem_in = gap_l; dt_in = dt; quot_in = '0; mcnt_in = '0;
         end
         OP_DIV: begin
            rem_in = r_ge ? 32'(r2 - {1'b0, dt_ff}) : r2[31:0];
            quot_in = {quot_ff[H_W-2:0], r_ge};
            mcnt_in = mcnt_ff + MC_W'(1);
         end
         OP_BAS1: u2_in = quot_ff * quot_ff;
         OP_BAS2: u3_in = u2_ff * quot_ff;
         OP_BAS3: begin
            b0_in = base_round(2 * h3 - 3 * h2 + one48);
            b1_in = base_round(3 * h2 - 2 * h3);
            b2_in = base_round(h3 - 2 * h2 + uu);
            b3_in = base_round(h3 - h2);
            mcnt_in = '0; acc_in = '0;
         end
         OP_MUL, OP_TMUL: prod_in = mul_p;
         OP_ACC: begin
            acc_in = acc_sum;
            if (term == 2'd3) begin
               acc_in = '0;
               case (comp)
                  2'd0:    vres_in.x = blend_res;
                  2'd1:    vres_in.y = blend_res;
                  default: vres_in.z = blend_res;
               endcase
            end
            mcnt_in = mcnt_ff + MC_W'(1);
         end
         OP_TAN_RDP: ram_raddr = (idx_ff == '0) ? '0 : KEY_AW'(idx_ff - CNT_W'(1));
         OP_TAN_RDN: begin
            ram_raddr = (idx_ff + CNT_W'(1) < count_ff) ? KEY_AW'(idx_ff + CNT_W'(1))
                                                      : idx_ff[KEY_AW-1:0];
            reca_in = rd_val;
         end
         OP_TAN_LAT: begin recb_in = rd_val; mcnt_in = '0; end
         OP_TACC: begin
            case (mcnt_ff[1:0])
               2'd0:    vres_in.x = card_res;
               2'd1:    vres_in.y = card_res;
               default: vres_in.z = card_res;
            endcase
            mcnt_in = mcnt_ff + MC_W'(1);
         end
         OP_TAN_WR: begin
            ram_waddr = idx_ff[KEY_AW-1:0]; tan_we = 1'b1; tan_wdata = vres_ff;
            idx_in = idx_ff + CNT_W'(1);
         end
         OP_DEL_RD: ram_raddr = KEY_AW'(idx_ff + CNT_W'(1));
         OP_DEL_WR: begin
            ram_waddr = idx_ff[KEY_AW-1:0]; val_we = 1'b1; tan_we = 1'b1;
            idx_in = idx_ff + CNT_W'(1);
         end
         OP_DEL_END: count_in = count_ff - CNT_W'(1);
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            o_status_in = status_ff; o_pos_in = pos_ff; o_total_in = count_ff;
            o_val_in = (rtype_ff == RQ_EVAL) ? vres_ff : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         gap_ff <= MIN_GAP_RST;
         bias_ff <= BIAS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         gap_ff <= gap_in;
         bias_ff <= bias_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff <= rtype_in; t_ff <= t_in; vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
      kidx_ff <= kidx_in; lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in;
      mid_ff <= mid_in; reca_ff <= reca_in; recb_ff <= recb_in;
      tana_ff <= tana_in; tanb_ff <= tanb_in; rem_ff <= rem_in; dt_ff <= dt_in;
      quot_ff <= quot_in; u2_ff <= u2_in; u3_ff <= u3_in;
      b0_ff <= b0_in; b1_ff <= b1_in; b2_ff <= b2_in; b3_ff <= b3_in;
      mcnt_ff <= mcnt_in; prod_ff <= prod_in; acc_ff <= acc_in; vres_ff <= vres_in;
      status_ff <= status_in; pos_ff <= pos_in;
      o_status_ff <= o_status_in; o_pos_ff <= o_pos_in; o_val_ff <= o_val_in;
      o_total_ff <= o_total_in;
   end

   always_comb begin
      stat.req_valid  = req_ch.valid;
      stat.is_add     = rtype_ff == RQ_ADD;
      stat.is_del     = rtype_ff == RQ_DEL;
      stat.is_eval    = rtype_ff == RQ_EVAL;
      stat.is_build   = rtype_ff == RQ_BUILD;
      stat.cnt_zero   = count_ff == '0;
      stat.cnt_one    = count_ff == CNT_W'(1);
      stat.full       = count_ff >= CNT_W'(MAX_KEYS);
      stat.kidx_bad   = {1'b0, kidx_ff} >= count_ff;
      stat.srch_done  = lo_ff >= hi_ff;
      stat.too_close  = (c_nz && gap_l < gap_ff) || (c_lt_n && gap_r < gap_ff);
      stat.ev_blend   = c_nz && c_lt_n && !same && dt != '0;
      stat.sh_done    = idx_ff == lo_ff;
      stat.del_done   = idx_ff + CNT_W'(1) >= count_ff;
      stat.div_done   = mcnt_ff == DIV_LAST;
      stat.mac_last   = mcnt_ff == MAC_LAST;
      stat.tcomp_last = mcnt_ff == TCOMP_LAST;
      stat.tan_last   = idx_ff + CNT_W'(1) == count_ff;
      stat.out_busy   = rsp_valid_ff && !rsp_ch.ready;
   end

   assign req_ch.ready     = cmd.idle;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = o_status_ff;
   assign rsp_ch.key_pos   = o_pos_ff;
   assign rsp_ch.out_x     = o_val_ff.x;
   assign rsp_ch.out_y     = o_val_ff.y;
   assign rsp_ch.out_z     = o_val_ff.z;
   assign rsp_ch.key_total = o_total_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/hkc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hkc_ctrl
   import hkc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);
   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (stat.req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (stat.is_add)        state_in = stat.full ? S_FINISH : S_SRCH_RD;
            else if (stat.is_del)   state_in = stat.kidx_bad ? S_FINISH : S_DEL_RD;
            else if (stat.is_eval)  state_in = stat.cnt_zero ? S_FINISH : S_SRCH_RD;
            else if (stat.is_build)
               state_in = (stat.cnt_zero || stat.cnt_one) ? S_FINISH : S_TAN_RDP;
            else                    state_in = S_FINISH;
         end
         S_SRCH_RD:   state_in = stat.srch_done ? S_RD_A : S_SRCH_CMP;
         S_SRCH_CMP:  state_in = S_SRCH_RD;
         S_RD_A:      state_in = S_RD_B;
         S_RD_B:      state_in = S_LAT_B;
         S_LAT_B:     state_in = stat.is_add ? S_ADD_CHECK : S_EV_CHECK;
         S_ADD_CHECK: state_in = stat.too_close ? S_FINISH : S_SH_RD;
         S_SH_RD:     state_in = stat.sh_done ? S_FINISH : S_SH_WR;
         S_SH_WR:     state_in = S_SH_RD;
         S_EV_CHECK:  state_in = stat.ev_blend ? S_DIV : S_FINISH;
         S_DIV:       if (stat.div_done) state_in = S_BAS1;
         S_BAS1:      state_in = S_BAS2;
         S_BAS2:      state_in = S_BAS3;
         S_BAS3:      state_in = S_MUL;
         S_MUL:       state_in = S_ACC;
         S_ACC:       state_in = stat.mac_last ? S_FINISH : S_MUL;
         S_TAN_RDP:   state_in = S_TAN_RDN;
         S_TAN_RDN:   state_in = S_TAN_LAT;
         S_TAN_LAT:   state_in = S_TMUL;
         S_TMUL:      state_in = S_TACC;
         S_TACC:      state_in = stat.tcomp_last ? S_TAN_WR : S_TMUL;
         S_TAN_WR:    state_in = stat.tan_last ? S_FINISH : S_TAN_RDP;
         S_DEL_RD:    state_in = stat.del_done ? S_FINISH : S_DEL_WR;
         S_DEL_WR:    state_in = S_DEL_RD;
         S_FINISH:    if (!stat.out_busy) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.idle = state_ff == S_IDLE;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_DISPATCH:  cmd.op = OP_DISPATCH;
         S_SRCH_RD:   cmd.op = stat.srch_done ? OP_NONE : OP_SRCH_RD;
         S_SRCH_CMP:  cmd.op = OP_SRCH_CMP;
         S_RD_A:      cmd.op = OP_RD_A;
         S_RD_B:      cmd.op = OP_RD_B;
         S_LAT_B:     cmd.op = OP_LAT_B;
         S_ADD_CHECK: cmd.op = OP_ADD_CHECK;
         S_SH_RD:     cmd.op = stat.sh_done ? OP_INS_WR : OP_SH_RD;
         S_SH_WR:     cmd.op = OP_SH_WR;
         S_EV_CHECK:  cmd.op = OP_EV_CHECK;
         S_DIV:       cmd.op = OP_DIV;
         S_BAS1:      cmd.op = OP_BAS1;
         S_BAS2:      cmd.op = OP_BAS2;
         S_BAS3:      cmd.op = OP_BAS3;
         S_MUL:       cmd.op = OP_MUL;
         S_ACC:       cmd.op = OP_ACC;
         S_TAN_RDP:   cmd.op = OP_TAN_RDP;
         S_TAN_RDN:   cmd.op = OP_TAN_RDN;
         S_TAN_LAT:   cmd.op = OP_TAN_LAT;
         S_TMUL:      cmd.op = OP_TMUL;
         S_TACC:      cmd.op = OP_TACC;
         S_TAN_WR:    cmd.op = OP_TAN_WR;
         S_DEL_RD:    cmd.op = stat.del_done ? OP_DEL_END : OP_DEL_RD;
         S_DEL_WR:    cmd.op = OP_DEL_WR;
         S_FINISH:    cmd.op = stat.out_busy ? OP_NONE : OP_FINISH;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/hermite_keyframe_curve.sv =====
// Keyframe curve: a time-sorted table of up to 64 3-D keys with tangents.
// req_ch carries one request (add, delete, evaluate, build tangents, clear);
// rsp_ch returns exactly one result per request, in order. Both channels
// transfer when valid and ready are high at a rising clock edge.
// csr_we/csr_index/csr_wdata write min_gap (index 0) and tangent_bias
// (index 1); write only while no request is in flight.
// One request is worked at a time. req_ch.ready is high while the control
// sequencer is idle, even if an earlier result still waits on rsp_ch.
// Request time is set by the registered-read key memories (searching and moving
// keys alternate a read state with a compare or write state) and the shared
// multiplier. Steps: search is a binary search; add searches, then moves up the
// keys from the slot upward; evaluate searches, then, when blending, runs the
// divider, the basis terms and 12 products; delete moves down the keys above the
// index; build makes a tangent per key; clear resets the key count. Synchronous
// reset empties the table and restores min_gap 10.0 and tangent_bias 0.5. A stalled
// receiver holds the result register; a finished request then waits until it
// is taken.
`timescale 1ns / 1ps
`default_nettype none
module hermite_keyframe_curve
   import hkc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   hkc_req_if.sink          req_ch,
   hkc_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   dp_cmd_type  cmd;
   dp_stat_type stat;

   hkc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .stat(stat), .cmd(cmd)
   );

   hkc_datapath u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_ch(req_ch), .rsp_ch(rsp_ch), .cmd(cmd), .stat(stat)
   );

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (cmd.op == OP_DISPATCH))
      else $error("accepted request not dispatched");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result register overwritten while stalled");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.key_total <= 7'(MAX_KEYS)))
      else $error("key total out of range");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
   import hkc_pkg::*;
();

   typedef struct {
      logic [2:0]         kind;
      logic [31:0]        t;
      logic signed [31:0] x, y, z;
      logic [5:0]         idx;
   } curve_req_type;

   typedef struct {
      logic [2:0]         status;
      logic [5:0]         pos;
      logic signed [31:0] x, y, z;
      logic [6:0]         total;
   } curve_rsp_type;

   // Tracks the key table and holds the results still owed by the block.
   class curve_scoreboard_type;
      logic [31:0]        key_t [MAX_KEYS];
      logic signed [31:0] key_v [MAX_KEYS][3];
      logic signed [31:0] tan_v [MAX_KEYS][3];
      int                 held;
      int                 cur_key;
      logic [31:0]        min_gap;
      logic signed [31:0] bias;
      curve_rsp_type      owed[$];
      int                 errors;

      function void clear_all();
         foreach (tan_v[i, c]) tan_v[i][c] = '0;
         held = 0;
         cur_key = 0;
         min_gap = MIN_GAP_RST;
         bias = BIAS_RST;
         errors = 0;
      endfunction

      function void write_reg(logic index, logic [31:0] data);
         if (index == CSR_MIN_GAP) min_gap = data;
         else bias = data;
      endfunction

      function logic signed [31:0] sat(logic signed [79:0] v);
         if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -80'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // -1 before the first key, held at or after the last, else last key <= t
      function int find_segment(logic [31:0] t);
         int lo, hi, mid;
         lo = 0;
         hi = held - 1;
         if (key_t[0] > t) return -1;
         if (key_t[held-1] <= t) return held;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (key_t[mid] <= t) lo = mid;
            else hi = mid;
         end
         return lo;
      endfunction

      function void insert_key(int pos, curve_req_type r);
         for (int i = held; i > pos; i--) begin
            key_t[i] = key_t[i-1];
            key_v[i] = key_v[i-1];
            tan_v[i] = tan_v[i-1];
         end
         key_t[pos] = r.t;
         key_v[pos][0] = r.x;
         key_v[pos][1] = r.y;
         key_v[pos][2] = r.z;
         for (int c = 0; c < 3; c++) tan_v[pos][c] = '0;
         held++;
      endfunction

      function logic signed [31:0] cardinal_tan(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [79:0] d, bb, p, m;
         d = a;
         bb = b;
         d = d - bb;
         bb = bias;
         p = d * bb;
         if (p >= 0) m = (p + 32768) >>> 16;
         else m = -((-p + 32768) >>> 16);
         return sat(m);
      endfunction

      function longint round18(longint v);
         return (v + (longint'(1) << 17)) >>> 18;
      endfunction

      function curve_rsp_type predict(curve_req_type r);
         curve_rsp_type e;
         int f, a, n;
         logic [31:0] dt;
         longint u, h, h2, h3;
         longint b [4];
         logic signed [79:0] s, w;
         e = '{default: '0};
         case (r.kind)
            RQ_ADD: begin
               if (held >= MAX_KEYS) e.status = ST_FULL;
               else if (held == 0) insert_key(0, r);
               else begin
                  f = find_segment(r.t);
                  if (f >= held) begin
                     if (r.t - key_t[held-1] < min_gap) e.status = ST_CLOSE;
                     else begin
                        e.pos = 6'(held);
                        insert_key(held, r);
                     end
                  end else if (f < 0) begin
                     if (key_t[0] - r.t < min_gap) e.status = ST_CLOSE;
                     else insert_key(0, r);
                  end else if (r.t - key_t[f] < min_gap || key_t[f+1] - r.t < min_gap) begin
                     e.status = ST_CLOSE;
                  end else begin
                     e.pos = 6'(f + 1);
                     insert_key(f + 1, r);
                  end
               end
            end
            RQ_DEL: begin
               if (r.idx >= held) e.status = ST_BAD;
               else begin
                  for (int i = r.idx; i + 1 < held; i++) begin
                     key_t[i] = key_t[i+1];
                     key_v[i] = key_v[i+1];
                     tan_v[i] = tan_v[i+1];
                  end
                  held--;
               end
            end
            RQ_EVAL: begin
               if (held == 0) begin
                  e.status = ST_EMPTY;
                  cur_key = 0;
               end else begin
                  f = (held == 1) ? -1 : find_segment(r.t);
                  a = (f < 0) ? 0 : (f >= held) ? held - 1 : f;
                  e.x = key_v[a][0];
                  e.y = key_v[a][1];
                  e.z = key_v[a][2];
                  if (f >= 0 && f < held) begin
                     n = a + 1;
                     dt = key_t[n] - key_t[a];
                     if (key_v[a] != key_v[n] && dt != 0 && r.t >= key_t[a]) begin
                        h = ({32'd0, r.t - key_t[a]} << 16) / {32'd0, dt};
                        if (h > 64'hFFFF) h = 64'hFFFF;
                        u = h;
                        h2 = (u * u) << 16;
                        h3 = u * u * u;
                        b[0] = round18(2 * h3 - 3 * h2 + (longint'(1) << 48));
                        b[1] = round18(-2 * h3 + 3 * h2);
                        b[2] = round18(h3 - 2 * h2 + (u << 32));
                        b[3] = round18(h3 - h2);
                        for (int c = 0; c < 3; c++) begin
                           s = 0;
                           w = key_v[a][c]; s = s + w * b[0];
                           w = key_v[n][c]; s = s + w * b[1];
                           w = tan_v[a][c]; s = s + w * b[2];
                           w = tan_v[n][c]; s = s + w * b[3];
                           w = sat((s + (80'sd1 << 29)) >>> 30);
                           if (c == 0) e.x = w[31:0];
                           else if (c == 1) e.y = w[31:0];
                           else e.z = w[31:0];
                        end
                     end
                  end
                  cur_key = a;
                  e.pos = 6'(a);
               end
            end
            RQ_BUILD: begin
               if (held == 0) e.status = ST_EMPTY;
               else if (held >= 2) begin
                  logic signed [31:0] prev [3];
                  logic signed [31:0] here [3];
                  prev = key_v[0];
                  for (int i = 0; i < held; i++) begin
                     n = (i + 1 < held) ? i + 1 : i;
                     here = key_v[i];
                     for (int c = 0; c < 3; c++) tan_v[i][c] = cardinal_tan(key_v[n][c], prev[c]);
                     prev = here;
                  end
               end
            end
            RQ_CLEAR: begin
               held = 0;
               cur_key = 0;
            end
            default: ;
         endcase
         e.total = 7'(held);
         return e;
      endfunction

      function void note_request(curve_req_type r);
         owed.insert(owed.size(), predict(r));
      endfunction

      function void check_result(curve_rsp_type got);
         curve_rsp_type e;
         if (owed.size() == 0) begin
            $display("%0t: result with none outstanding: status %0d", $time, got.status);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.pos !== e.pos) begin
            $display("%0t: key_pos exp %0d got %0d", $time, e.pos, got.pos);
            errors++;
         end
         if (got.x !== e.x) begin
            $display("%0t: out_x exp %h got %h", $time, e.x, got.x);
            errors++;
         end
         if (got.y !== e.y) begin
            $display("%0t: out_y exp %h got %h", $time, e.y, got.y);
            errors++;
         end
         if (got.z !== e.z) begin
            $display("%0t: out_z exp %h got %h", $time, e.z, got.z);
            errors++;
         end
         if (got.total !== e.total) begin
            $display("%0t: key_total exp %0d got %0d", $time, e.total, got.total);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   hkc_req_if req_bus ();
   hkc_rsp_if rsp_bus ();

   hermite_keyframe_curve i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   curve_scoreboard_type curve_sb;
   int src_idle;
   int snk_idle;
   bit hold_req;
   int hold_cnt;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.req_type  = '0;
      req_bus.at_time   = '0;
      req_bus.in_x      = '0;
      req_bus.in_y      = '0;
      req_bus.in_z      = '0;
      req_bus.key_index = '0;
      rsp_bus.ready     = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_MIN_GAP;
      csr_wdata         = '0;
      reset             = 1'b1;
      src_idle          = 0;
      snk_idle          = 0;
      hold_req          = 1'b0;
      hold_cnt          = 0;
      curve_sb          = new();
      curve_sb.clear_all();
   end

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            curve_sb.check_result('{rsp_bus.status, rsp_bus.key_pos, rsp_bus.out_x,
                                    rsp_bus.out_y, rsp_bus.out_z, rsp_bus.key_total});
         if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 300;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= snk_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= 5000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic send_request(curve_req_type r);
      while ($urandom_range(99) < src_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= r.kind;
      req_bus.at_time   <= r.t;
      req_bus.in_x      <= r.x;
      req_bus.in_y      <= r.y;
      req_bus.in_z      <= r.z;
      req_bus.key_index <= r.idx;
      do @(posedge clock); while (!req_bus.ready);
      curve_sb.note_request(r);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (curve_sb.owed.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      curve_sb.write_reg(index, data);
      @(posedge clock);
   endtask

   task automatic send_fields(logic [2:0] kind, logic [31:0] t, logic signed [31:0] x,
                              logic signed [31:0] y, logic signed [31:0] z, logic [5:0] idx);
      send_request('{kind, t, x, y, z, idx});
   endtask

   function automatic logic signed [31:0] pick_value(int c);
      int k;
      case ($urandom_range(2))
         0: return $urandom;
         1: return $urandom_range(2000) - 1000;
         default: begin
            if (curve_sb.held == 0) return $urandom;
            k = $urandom_range(curve_sb.held - 1);
            return curve_sb.key_v[k][c];
         end
      endcase
   endfunction

   function automatic curve_req_type pick_request(bit fill);
      curve_req_type r;
      int roll, k;
      roll = fill ? 0 : $urandom_range(99);
      if (roll < 38) r.kind = RQ_ADD;
      else if (roll < 70) r.kind = RQ_EVAL;
      else if (roll < 80) r.kind = RQ_DEL;
      else if (roll < 87) r.kind = RQ_BUILD;
      else if (roll < 90) r.kind = RQ_CLEAR;
      else if (roll < 93) r.kind = 3'(5 + $urandom_range(2));
      else r.kind = RQ_EVAL;
      k = (curve_sb.held > 0) ? $urandom_range(curve_sb.held - 1) : 0;
      case ($urandom_range(3))
         0: r.t = $urandom;
         1: r.t = $urandom_range(4095);
         2: r.t = (curve_sb.held > 0) ? curve_sb.key_t[k] + $urandom_range(8191) - 4096
                                      : $urandom_range(8191);
         default: r.t = (curve_sb.held > 0) ? curve_sb.key_t[curve_sb.held-1] +
                                              $urandom_range(6000) : $urandom;
      endcase
      r.x = pick_value(0);
      r.y = pick_value(1);
      r.z = pick_value(2);
      if (curve_sb.held > 0 && $urandom_range(4) != 0)
         r.idx = 6'($urandom_range(curve_sb.held - 1));
      else r.idx = 6'($urandom_range(63));
      return r;
   endfunction

   initial begin
      logic [31:0] gaps [5];
      logic [31:0] biases [5];
      gaps   = '{32'd2560, 32'd0, 32'hFFFFFFFF, 32'd16, 32'd0};
      biases = '{32'd32768, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h00010000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, single key, ends, gaps, equal values, unused codes
      src_idle = 33;
      snk_idle = 87;
      send_fields(RQ_EVAL, 32'd50, 0, 0, 0, 0);
      send_fields(RQ_BUILD, 0, 0, 0, 0, 0);
      send_fields(RQ_DEL, 0, 0, 0, 0, 6'd0);
      send_fields(RQ_DEL, 0, 0, 0, 0, 6'd63);
      send_fields(RQ_ADD, 32'd1000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
      send_fields(RQ_EVAL, 32'd0, 0, 0, 0, 0);
      send_fields(RQ_EVAL, 32'd1000, 0, 0, 0, 0);
      send_fields(RQ_EVAL, 32'hFFFFFFFF, 0, 0, 0, 0);
      send_fields(RQ_BUILD, 0, 0, 0, 0, 0);
      send_fields(RQ_ADD, 32'd2000, 1, 2, 3, 0);
      send_fields(RQ_ADD, 32'hFFFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, -1, 0);
      send_fields(RQ_ADD, 32'd0, 5, 5, 5, 0);
      send_fields(RQ_ADD, 32'd5000, 7, 7, 7, 0);
      send_fields(RQ_ADD, 32'd6000, 9, 9, 9, 0);
      send_fields(RQ_EVAL, 32'd3000, 0, 0, 0, 0);
      send_fields(RQ_BUILD, 0, 0, 0, 0, 0);
      send_fields(RQ_EVAL, 32'd3000, 0, 0, 0, 0);
      send_fields(RQ_EVAL, 32'hFFFFFFF0, 0, 0, 0, 0);
      send_fields(RQ_ADD, 32'd20000, 7, 7, 7, 0);
      send_fields(RQ_EVAL, 32'd10000, 0, 0, 0, 0);
      send_fields(RQ_DEL, 0, 0, 0, 0, 6'd1);
      send_fields(3'd5, 0, 0, 0, 0, 0);
      send_fields(3'd6, 0, 0, 0, 0, 0);
      send_fields(3'd7, 0, 0, 0, 0, 0);
      send_fields(RQ_CLEAR, 0, 0, 0, 0, 0);
      send_fields(RQ_ADD, 32'd100000, 4, 4, 4, 0);
      send_fields(RQ_ADD, 32'd0, -4, -4, -4, 0);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_MIN_GAP, gaps[ph]);
         write_csr(CSR_BIAS, biases[ph]);
         if (ph < 2) begin
            src_idle = 33;
            snk_idle = 87;
         end else if (ph < 4) begin
            src_idle = 87;
            snk_idle = 33;
         end else begin
            src_idle = 0;
            snk_idle = 0;
            hold_req = 1'b1;
         end
         for (int n = 0; n < 185; n++)
            send_request(pick_request(ph == 1 && n < 75));
         // pause the sender until the block has answered everything
         drain();
      end

      repeat (20) @(posedge clock);
      if (curve_sb.owed.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, curve_sb.owed.size());
         curve_sb.errors++;
      end
      if (curve_sb.errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hkc_pkg.sv
hw/rtl/hkc_if.sv
hw/rtl/hkc_ram.sv
hw/rtl/hkc_datapath.sv
hw/rtl/hkc_ctrl.sv
hw/rtl/hermite_keyframe_curve.sv
tb/testbench.sv
